// ===== rtl/core/rpcf_pkg.sv =====
// Shared types and constants for the received-packet check with frequency correction.
package rpcf_pkg;

   localparam int unsigned SAMPLE_COUNT_WIDTH = 8;
   localparam int unsigned SUM_WIDTH          = 18;
   localparam int unsigned CORR_WIDTH         = 8;
   localparam int unsigned DIV_STEPS          = SUM_WIDTH;
   localparam int unsigned STEP_WIDTH         = $clog2(DIV_STEPS);
   localparam int unsigned MAX_SAMPLES_DEFAULT = 255;

   localparam logic [7:0] RX_BUFFER_LENGTH_RESET = 8'd64;
   localparam logic [6:0] MIN_FIFO_BYTES         = 7'd2;

   localparam logic [1:0] RES_GOOD      = 2'd0;
   localparam logic [1:0] RES_CRC_ERROR = 2'd1;
   localparam logic [1:0] RES_TOO_LONG  = 2'd2;
   localparam logic [1:0] RES_OVERFLOW  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_DIVIDE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic accum;
      logic div_init;
      logic div_step;
      logic update_corr;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic avg_go;
   } status_type;

endpackage

// ===== rtl/core/rpcf_ifs.sv =====
// Channel interfaces: packet request, result response and register write.
interface rpcf_req_if;
   logic              valid;
   logic              ready;
   logic [6:0]        fifo_byte_count;
   logic              fifo_overflow;
   logic [7:0]        packet_length;
   logic [7:0]        signal_strength;
   logic [7:0]        quality_byte;
   logic signed [7:0] freq_estimate;

   modport source (output valid, fifo_byte_count, fifo_overflow, packet_length,
                   signal_strength, quality_byte, freq_estimate, input ready);
   modport sink (input valid, fifo_byte_count, fifo_overflow, packet_length,
                 signal_strength, quality_byte, freq_estimate, output ready);
endinterface

interface rpcf_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        result_code;
   logic [7:0]        length_out;
   logic [7:0]        rssi_out;
   logic [6:0]        link_quality;
   logic signed [7:0] correction_out;
   logic              correction_written;
   logic              averaging_done;

   modport source (output valid, result_code, length_out, rssi_out, link_quality,
                   correction_out, correction_written, averaging_done, input ready);
   modport sink (input valid, result_code, length_out, rssi_out, link_quality,
                 correction_out, correction_written, averaging_done, output ready);
endinterface

interface rpcf_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/rpcf_ctrl.sv =====
// Controller state machine sequencing packet load, averaging division and result output.
module rpcf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rpcf_pkg::status_type status,
   output rpcf_pkg::cmd_type    cmd
);

   rpcf_pkg::state_type                state_ff, state_in;
   logic [rpcf_pkg::STEP_WIDTH-1:0]    step_ff, step_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rpcf_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rpcf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.avg_go ? rpcf_pkg::ST_INIT : rpcf_pkg::ST_FINISH;
            end
         end
         rpcf_pkg::ST_INIT:   state_in = rpcf_pkg::ST_DIVIDE;
         rpcf_pkg::ST_DIVIDE: begin
            if (step_ff == rpcf_pkg::STEP_WIDTH'(rpcf_pkg::DIV_STEPS - 1)) begin
               state_in = rpcf_pkg::ST_UPDATE;
            end
         end
         rpcf_pkg::ST_UPDATE: state_in = rpcf_pkg::ST_FINISH;
         rpcf_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = rpcf_pkg::ST_IDLE;
            end
         end
         default: state_in = rpcf_pkg::ST_IDLE;
      endcase
   end

   // Outputs and commands.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         rpcf_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
            cmd.accum = req_valid && status.avg_go;
         end
         rpcf_pkg::ST_INIT:   cmd.div_init    = 1'b1;
         rpcf_pkg::ST_DIVIDE: cmd.div_step    = 1'b1;
         rpcf_pkg::ST_UPDATE: cmd.update_corr = 1'b1;
         rpcf_pkg::ST_FINISH: cmd.load_out    = !rsp_valid_ff || rsp_ready;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      if (cmd.div_init) begin
         step_in = '0;
      end else if (cmd.div_step) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/rpcf_dp.sv =====
// Datapath: packet classification, averaging state, restoring divider and result register.
module rpcf_dp #(
   parameter int unsigned MAX_SAMPLES = rpcf_pkg::MAX_SAMPLES_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rpcf_pkg::cmd_type    cmd,
   output rpcf_pkg::status_type status,
   input  logic                 csr_write,
   input  logic [7:0]           csr_data,
   input  logic [6:0]           fifo_byte_count,
   input  logic                 fifo_overflow,
   input  logic [7:0]           packet_length,
   input  logic [7:0]           signal_strength,
   input  logic [7:0]           quality_byte,
   input  logic signed [7:0]    freq_estimate,
   output logic [1:0]           result_code,
   output logic [7:0]           length_out,
   output logic [7:0]           rssi_out,
   output logic [6:0]           link_quality,
   output logic signed [7:0]    correction_out,
   output logic                 correction_written,
   output logic                 averaging_done
);

   localparam int unsigned SW = rpcf_pkg::SUM_WIDTH;
   localparam int unsigned CW = rpcf_pkg::SAMPLE_COUNT_WIDTH;

   logic [7:0]    rx_buffer_length_ff;
   logic [SW-1:0] sum_ff, sum_in;
   logic [CW-1:0] count_ff;
   logic [7:0]    corr_ff;
   logic          written_ff;

   logic [1:0]    code_ff, code_in;
   logic [7:0]    len_ff;
   logic [7:0]    rssi_ff;
   logic [6:0]    lqi_ff;

   logic [CW-1:0] rem_ff;
   logic [SW-1:0] quo_ff;
   logic [CW:0]   trial;
   logic [CW:0]   trial_diff;
   logic [7:0]    corr_new;
   logic [SW-1:0] sum_mag;

   // Classification of the incoming packet.
   always_comb begin
      if (fifo_overflow || fifo_byte_count < rpcf_pkg::MIN_FIFO_BYTES) begin
         code_in = rpcf_pkg::RES_OVERFLOW;
      end else if (packet_length > rx_buffer_length_ff) begin
         code_in = rpcf_pkg::RES_TOO_LONG;
      end else if (!quality_byte[7]) begin
         code_in = rpcf_pkg::RES_CRC_ERROR;
      end else begin
         code_in = rpcf_pkg::RES_GOOD;
      end
   end

   assign status.avg_go = (code_in == rpcf_pkg::RES_GOOD) && (freq_estimate != '0)
                          && (count_ff < CW'(MAX_SAMPLES));

   assign sum_in = sum_ff + {{(SW-8){freq_estimate[7]}}, freq_estimate}
                          + {{(SW-8){corr_ff[7]}}, corr_ff};

   assign sum_mag    = sum_ff[SW-1] ? (~sum_ff + 1'b1) : sum_ff;
   assign trial      = {rem_ff, quo_ff[SW-1]};
   assign trial_diff = trial - {1'b0, count_ff};
   assign corr_new   = sum_ff[SW-1] ? (~quo_ff[7:0] + 1'b1) : quo_ff[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_buffer_length_ff <= rpcf_pkg::RX_BUFFER_LENGTH_RESET;
         sum_ff              <= '0;
         count_ff            <= '0;
         corr_ff             <= '0;
         written_ff          <= 1'b0;
      end else begin
         if (csr_write) begin
            rx_buffer_length_ff <= csr_data;
         end
         if (cmd.accum) begin
            sum_ff   <= sum_in;
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.load) begin
            written_ff <= 1'b0;
         end else if (cmd.update_corr) begin
            written_ff <= corr_new != corr_ff;
            corr_ff    <= corr_new;
         end
      end
   end

   // Captured packet fields and the shift-subtract divider.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         code_ff <= code_in;
         len_ff  <= packet_length;
         rssi_ff <= signal_strength;
         lqi_ff  <= quality_byte[6:0];
      end
      if (cmd.div_init) begin
         rem_ff <= '0;
         quo_ff <= sum_mag;
      end else if (cmd.div_step) begin
         if (!trial_diff[CW]) begin
            rem_ff <= trial_diff[CW-1:0];
            quo_ff <= {quo_ff[SW-2:0], 1'b1};
         end else begin
            rem_ff <= trial[CW-1:0];
            quo_ff <= {quo_ff[SW-2:0], 1'b0};
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         result_code        <= code_ff;
         length_out         <= (code_ff == rpcf_pkg::RES_GOOD) ? len_ff : '0;
         rssi_out           <= (code_ff == rpcf_pkg::RES_GOOD) ? rssi_ff : '0;
         link_quality       <= (code_ff == rpcf_pkg::RES_GOOD) ? lqi_ff : '0;
         correction_out     <= corr_ff;
         correction_written <= written_ff;
         averaging_done     <= count_ff == CW'(MAX_SAMPLES);
      end
   end

endmodule

// ===== rtl/core/rx_packet_check_freq_correction.sv =====
// Top level of the received-packet check with frequency-offset averaging.
//
// The req channel carries one end-of-packet beat: FIFO byte count and overflow
// flag, length byte, RSSI, the LQI/CRC byte and a signed frequency estimate.
// For each request beat exactly one beat leaves on the rsp channel with the
// packet classification, the reported RSSI and link quality for a good packet,
// and the current frequency correction with its change and done flags.
// The csr channel writes the largest accepted packet length; it is always
// ready and should only be written while the block is idle.
// A packet that takes no averaging step goes from IDLE straight to FINISH,
// where its result is loaded. A good packet with a nonzero estimate, while
// fewer than MAX_SAMPLES samples have been taken, adds to the running sum and
// divides it by the sample count in an 18-step restoring divider, one quotient
// bit per cycle; its result passes INIT, DIVIDE, UPDATE and FINISH, and no new
// packet is taken until its result has been loaded.
// One packet is processed at a time. The rsp output register lets the block
// take and process the next packet while a result still waits; if the receiver
// stalls, the next result is held internally until the register frees up.
// Synchronous reset clears the sum, count and correction, restores the length
// limit to 64 and drops rsp valid.
module rx_packet_check_freq_correction #(
   parameter int unsigned MAX_SAMPLES = rpcf_pkg::MAX_SAMPLES_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   rpcf_req_if.sink   req_bus,
   rpcf_rsp_if.source rsp_bus,
   rpcf_csr_if.sink   csr_bus
);

   rpcf_pkg::cmd_type    cmd;
   rpcf_pkg::status_type status;

   // Register writes are always taken.
   assign csr_bus.ready = 1'b1;

   rpcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rpcf_dp #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_bus.valid),
      .csr_data           (csr_bus.data),
      .fifo_byte_count    (req_bus.fifo_byte_count),
      .fifo_overflow      (req_bus.fifo_overflow),
      .packet_length      (req_bus.packet_length),
      .signal_strength    (req_bus.signal_strength),
      .quality_byte       (req_bus.quality_byte),
      .freq_estimate      (req_bus.freq_estimate),
      .result_code        (rsp_bus.result_code),
      .length_out         (rsp_bus.length_out),
      .rssi_out           (rsp_bus.rssi_out),
      .link_quality       (rsp_bus.link_quality),
      .correction_out     (rsp_bus.correction_out),
      .correction_written (rsp_bus.correction_written),
      .averaging_done     (rsp_bus.averaging_done)
   );

   // No new packet may be taken while the divider is running.
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> !req_bus.ready)
      else $error("request accepted during division");

   // A result register load never coincides with a request accept.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !cmd.load)
      else $error("result load overlaps packet load");

   // Only a good packet can change the correction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.correction_written |->
         rsp_bus.result_code == rpcf_pkg::RES_GOOD)
      else $error("correction changed on a rejected packet");

   // The cycle after reset shows no result.
   assert property (@(posedge clock) $past(reset) |-> !rsp_bus.valid)
      else $error("result valid right after reset");

endmodule
